// ===== src/tng_pkg.sv =====
// ----------------------------------------------------------------------------
// tng_pkg: shared types and constants of the torus neighborhood index generator
// Register map, slot fields and sequencer phase codes.
// ----------------------------------------------------------------------------
package tng_pkg;

  // Configuration register file
  localparam int unsigned CFG_W     = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned RADIUS_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_COUNT = 2'd0,
    REG_COLUMNS    = 2'd1,
    REG_RADIUS     = 2'd2,
    REG_ADD_ARMS   = 2'd3
  } cfg_reg_e;

  localparam logic [CFG_W-1:0]    CELL_COUNT_RST = 17'd65536;
  localparam logic [CFG_W-1:0]    COLUMNS_RST    = 17'd256;
  localparam logic [RADIUS_W-1:0] RADIUS_RST     = 2'd1;

  // Neighbor list
  localparam int unsigned SLOT_W = 6;
  localparam logic [SLOT_W-1:0] ARM_COUNT = 6'd4;

  // Sequencer walk: the cell itself, the square, then the four arms
  typedef enum logic [1:0] {
    PH_CENTER,
    PH_SQUARE,
    PH_ARM
  } seq_phase_e;

  // Per-beat tag that rides along the datapath
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              last;
  } tng_meta_t;

endpackage

// ===== src/tng_wrap_pipe.sv =====
// ----------------------------------------------------------------------------
// tng_wrap_pipe: pipelined modulo wrap of a linear cell index
// Adds a signed offset to the cell, then reduces the sum modulo the cell
// count with one restoring subtract stage per quotient bit.
// ----------------------------------------------------------------------------
module tng_wrap_pipe import tng_pkg::*; #(
  parameter int unsigned INDEX_BITS = 16,
  parameter int unsigned OFF_W      = 22
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [CFG_W-1:0]             modulus_i,
  input  logic                         valid_i,
  input  logic [INDEX_BITS-1:0]        cell_i,
  input  logic signed [OFF_W-1:0]      offset_i,
  input  tng_meta_t                    meta_i,
  output logic                         valid_o,
  output logic [INDEX_BITS-1:0]        index_o,
  output tng_meta_t                    meta_o
);

  localparam int unsigned MAG_W = (INDEX_BITS > OFF_W - 1) ? INDEX_BITS : OFF_W - 1;
  localparam int unsigned SUM_W = MAG_W + 2;
  localparam int unsigned ABS_W = SUM_W - 1;
  // |sum| < 2^ABS_W <= modulus * 2^ABS_W, so ABS_W quotient bits suffice
  localparam int unsigned NSTG  = ABS_W;
  localparam int unsigned CMP_W = ABS_W + CFG_W;

  logic                     vld_q  [NSTG+1];
  logic                     neg_q  [NSTG+1];
  logic [ABS_W-1:0]         rem_q  [NSTG+1];
  tng_meta_t                meta_q [NSTG+1];

  // Sum, sign and magnitude
  logic signed [SUM_W-1:0] sum;
  logic                    sum_neg;
  logic [SUM_W-1:0]        sum_mag;

  assign sum = signed'(SUM_W'(cell_i)) + SUM_W'(offset_i);
  assign sum_neg = sum[SUM_W-1];
  assign sum_mag = sum_neg ? SUM_W'(-sum) : SUM_W'(sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0]  <= sum_neg;
      rem_q[0]  <= sum_mag[ABS_W-1:0];
      meta_q[0] <= meta_i;
    end
  end

  // Restoring reduction, highest multiple first
  for (genvar j = 0; j < NSTG; j++) begin : g_stage
    logic [CMP_W-1:0] mult;
    logic [CMP_W-1:0] rem_x;
    logic [ABS_W-1:0] rem_d;

    assign mult  = CMP_W'(modulus_i) << (NSTG - 1 - j);
    assign rem_x = CMP_W'(rem_q[j]);
    assign rem_d = (rem_x >= mult) ? ABS_W'(rem_x - mult) : rem_q[j];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[j+1]  <= neg_q[j];
        rem_q[j+1]  <= rem_d;
        meta_q[j+1] <= meta_q[j];
      end
    end
  end

  // Negative sums fold back from the top of the range
  logic [CFG_W-1:0]      rem_fin;
  logic [CFG_W-1:0]      wrap_d;
  logic                  out_vld_q;
  logic [INDEX_BITS-1:0] out_idx_q;
  tng_meta_t             out_meta_q;

  assign rem_fin = CFG_W'(rem_q[NSTG]);
  assign wrap_d  = (neg_q[NSTG] && (rem_fin != '0)) ? modulus_i - rem_fin : rem_fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_idx_q  <= INDEX_BITS'(wrap_d);
      out_meta_q <= meta_q[NSTG];
    end
  end

  assign valid_o = out_vld_q;
  assign index_o = out_idx_q;
  assign meta_o  = out_meta_q;

endmodule

// ===== src/torus_neighbourhood_index_gen.sv =====
// ----------------------------------------------------------------------------
// torus_neighbourhood_index_gen: neighbor index list of a cell on a torus
// Walks the neighborhood of one cell and emits each wrapped linear index.
// ----------------------------------------------------------------------------
// One input beat (a cell index) yields one output beat per neighbor, one per
// cycle while the output is not stalled: 1 + ((2r+1)^2 - 1) + 4*arms beats,
// that is 5 at radius 0, 9 or 13 at radius 1, 25 or 29 at radius 2 and 49 or
// 53 at radius 3. The front-end sequencer issues one neighbor offset per cycle
// and takes the next cell in the cycle its final neighbor leaves, so cells
// follow back to back and, unless stalled, the output runs at one beat per
// cycle. The first beat of a cell passes two front stages, one sum stage, one
// reduction stage per bit of the sum magnitude and one output stage. An output
// stall freezes the whole pipe. The user must write configuration only while
// no cell is in flight; the block itself does not enforce it.
module torus_neighbourhood_index_gen import tng_pkg::*; #(
  parameter int unsigned MAX_RADIUS = 3,
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  // cell channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [INDEX_BITS-1:0] cell_index_i,
  // neighbor channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [INDEX_BITS-1:0] neighbour_index_o,
  output logic [SLOT_W-1:0]     slot_o,
  output logic                  last_o
);

  localparam int unsigned DW    = $clog2(MAX_RADIUS + 2) + 2;
  localparam int unsigned OFF_W = CFG_W + DW;
  localparam logic [32:0] LIMIT = 33'(1) << INDEX_BITS;
  localparam logic signed [DW-1:0] ONE_S = DW'(1);

  // Configuration registers
  logic [CFG_W-1:0]    cell_count_q;
  logic [CFG_W-1:0]    columns_q;
  logic [RADIUS_W-1:0] radius_q;
  logic                add_arms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_count_q <= CELL_COUNT_RST;
      columns_q    <= COLUMNS_RST;
      radius_q     <= RADIUS_RST;
      add_arms_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_CELL_COUNT: cell_count_q <= cfg_wdata_i;
        REG_COLUMNS:    columns_q    <= cfg_wdata_i;
        REG_RADIUS:     radius_q     <= cfg_wdata_i[RADIUS_W-1:0];
        REG_ADD_ARMS:   add_arms_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Effective settings: clamped modulus and radius, forced arms
  logic [CFG_W-1:0]    modulus;
  logic [RADIUS_W-1:0] r_eff;
  logic                arms_eff;
  logic [SLOT_W-1:0]   side;
  logic [SLOT_W-1:0]   total_m1;
  logic signed [DW-1:0] r_s;
  logic signed [DW-1:0] d_s;

  always_comb begin
    if (cell_count_q == '0) begin
      modulus = CFG_W'(1);
    end else if (33'(cell_count_q) > LIMIT) begin
      modulus = LIMIT[CFG_W-1:0];
    end else begin
      modulus = cell_count_q;
    end
  end

  assign r_eff    = (radius_q > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius_q;
  assign arms_eff = add_arms_q || (r_eff == '0);
  assign side     = SLOT_W'({r_eff, 1'b1});
  assign total_m1 = SLOT_W'(side * side) + (arms_eff ? ARM_COUNT : '0) - SLOT_W'(1);
  assign r_s      = signed'(DW'(r_eff));
  assign d_s      = r_s + ONE_S;

  // Stage 0: neighbor sequencer
  logic                 s0_valid_q;
  logic [INDEX_BITS-1:0] s0_cell_q;
  logic [SLOT_W-1:0]    s0_slot_q;
  logic                 s0_last_q;
  logic signed [DW-1:0] s0_dr_q;
  logic signed [DW-1:0] s0_dc_q;
  seq_phase_e           s0_phase_q;
  logic [1:0]           s0_arm_q;

  logic                 adv;
  logic                 take;
  logic signed [DW-1:0] nx_dr;
  logic signed [DW-1:0] nx_dc;
  seq_phase_e           nx_phase;
  logic [1:0]           nx_arm;
  logic                 to_arms;
  logic [SLOT_W-1:0]    nx_slot;

  assign adv        = !out_valid_o || !out_stall_i;
  assign take       = adv && (!s0_valid_q || s0_last_q);
  assign in_stall_o = !take;
  assign nx_slot    = s0_slot_q + SLOT_W'(1);

  // Next offset in the walk
  always_comb begin
    nx_dr    = s0_dr_q;
    nx_dc    = s0_dc_q;
    nx_phase = s0_phase_q;
    nx_arm   = s0_arm_q;
    to_arms  = 1'b0;
    case (s0_phase_q)
      PH_CENTER: begin
        if (r_eff == '0) begin
          to_arms = 1'b1;
        end else begin
          nx_phase = PH_SQUARE;
          nx_dr    = -r_s;
          nx_dc    = -r_s;
        end
      end
      PH_SQUARE: begin
        if (s0_dc_q == r_s) begin
          if (s0_dr_q == r_s) begin
            to_arms = 1'b1;
          end else begin
            nx_dr = s0_dr_q + ONE_S;
            nx_dc = -r_s;
          end
        end else if ((s0_dr_q == '0) && (s0_dc_q == -ONE_S)) begin
          nx_dc = ONE_S;  // skip the center cell
        end else begin
          nx_dc = s0_dc_q + ONE_S;
        end
      end
      default: begin
        nx_arm = s0_arm_q + 2'd1;
      end
    endcase
    if (to_arms) begin
      nx_phase = PH_ARM;
      nx_arm   = 2'd0;
    end
    // Arms in order N, W, E, S
    if (nx_phase == PH_ARM) begin
      unique case (nx_arm)
        2'd0: begin nx_dr = -d_s; nx_dc = '0;   end
        2'd1: begin nx_dr = '0;   nx_dc = -d_s; end
        2'd2: begin nx_dr = '0;   nx_dc = d_s;  end
        default: begin nx_dr = d_s; nx_dc = '0; end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (adv) begin
      s0_valid_q <= (s0_valid_q && !s0_last_q) || in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (s0_valid_q && !s0_last_q) begin
        s0_slot_q  <= nx_slot;
        s0_last_q  <= (nx_slot == total_m1);
        s0_dr_q    <= nx_dr;
        s0_dc_q    <= nx_dc;
        s0_phase_q <= nx_phase;
        s0_arm_q   <= nx_arm;
      end else if (in_valid_i) begin
        s0_cell_q  <= cell_index_i;
        s0_slot_q  <= '0;
        s0_last_q  <= (total_m1 == '0);
        s0_dr_q    <= '0;
        s0_dc_q    <= '0;
        s0_phase_q <= PH_CENTER;
        s0_arm_q   <= 2'd0;
      end
    end
  end

  // Stage 1: linear offset dr*columns + dc
  logic signed [OFF_W:0]   prod;
  logic signed [OFF_W-1:0] off_d;
  logic                    s1_valid_q;
  logic [INDEX_BITS-1:0]   s1_cell_q;
  logic signed [OFF_W-1:0] s1_off_q;
  tng_meta_t               s1_meta_q;

  assign prod  = s0_dr_q * $signed({1'b0, columns_q});
  assign off_d = prod[OFF_W-1:0] + {{(OFF_W-DW){s0_dc_q[DW-1]}}, s0_dc_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cell_q      <= s0_cell_q;
      s1_off_q       <= off_d;
      s1_meta_q.slot <= s0_slot_q;
      s1_meta_q.last <= s0_last_q;
    end
  end

  // Wrap and output register
  tng_meta_t out_meta;

  tng_wrap_pipe #(
    .INDEX_BITS (INDEX_BITS),
    .OFF_W      (OFF_W)
  ) u_wrap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .modulus_i (modulus),
    .valid_i   (s1_valid_q),
    .cell_i    (s1_cell_q),
    .offset_i  (s1_off_q),
    .meta_i    (s1_meta_q),
    .valid_o   (out_valid_o),
    .index_o   (neighbour_index_o),
    .meta_o    (out_meta)
  );

  assign slot_o = out_meta.slot;
  assign last_o = out_meta.last;

endmodule

// ===== src/tng_checker.sv =====
// ----------------------------------------------------------------------------
// tng_checker: port-level checks of the neighbor index generator
// Tracks slot order and cells in flight from the ports alone.
// ----------------------------------------------------------------------------
module tng_checker import tng_pkg::*; #(
  parameter int unsigned INDEX_BITS = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [INDEX_BITS-1:0] neighbour_index_o,
  input logic [SLOT_W-1:0]     slot_o,
  input logic                  last_o
);

  logic              in_beat;
  logic              out_beat;
  logic [SLOT_W-1:0] exp_slot_q;
  logic [7:0]        open_q;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;

  // Expected slot of the next output beat, cells opened but not closed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_slot_q <= '0;
      open_q     <= '0;
    end else begin
      if (out_beat) begin
        exp_slot_q <= last_o ? '0 : slot_o + SLOT_W'(1);
      end
      open_q <= open_q + 8'(in_beat) - 8'(out_beat && last_o);
    end
  end

  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> slot_o == exp_slot_q)
    else $error("neighbor slot out of order");

  a_min_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> slot_o >= SLOT_W'(4))
    else $error("neighbor list shorter than five");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> open_q != '0)
    else $error("output beat without an accepted cell");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(neighbour_index_o)
      && $stable(slot_o) && $stable(last_o))
    else $error("stalled output beat changed");

endmodule

bind torus_neighbourhood_index_gen tng_checker #(.INDEX_BITS(INDEX_BITS)) u_tng_checker (.*);
